>>> hw/rtl/bcar_pkg.sv
// Shared types and constants for the block cache tag and replacement logic.
`timescale 1ns / 1ps

package bcar_pkg;

  localparam int unsigned TagW      = 32;
  localparam int unsigned WayFieldW = 2;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAlloc
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic alloc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic is_write;
  } dp_status_t;

endpackage

>>> hw/rtl/bcar_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface bcar_req_if
  import bcar_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [TagW-1:0] block_number;

  modport source (output valid, output req_type, output block_number, input ready);
  modport sink (input valid, input req_type, input block_number, output ready);
endinterface

interface bcar_rsp_if
  import bcar_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WayFieldW-1:0] way;
  logic                 fill;

  modport source (output valid, output hit, output way, output fill, input ready);
  modport sink (input valid, input hit, input way, input fill, output ready);
endinterface

>>> hw/rtl/bcar_ctrl.sv
// Controller state machine that sequences the way scan, allocation and result transfer.
`timescale 1ns / 1ps

module bcar_ctrl
  import bcar_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (sts_i.match || (sts_i.last && sts_i.is_write)) begin
          if (out_free) begin
            cmd_o.step = 1'b1;
            cmd_o.emit = 1'b1;
            state_d    = StIdle;
          end
        end else if (sts_i.last) begin
          cmd_o.step = 1'b1;
          state_d    = StAlloc;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StAlloc: begin
        if (out_free) begin
          cmd_o.alloc = 1'b1;
          cmd_o.emit  = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/bcar_dp.sv
// Datapath with way tags, saturating ages, scan pointer, victim tracking and result register.
`timescale 1ns / 1ps

module bcar_dp
  import bcar_pkg::*;
#(
  parameter int unsigned NWAYS    = 3,
  parameter int unsigned AGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_type_i,
  input  logic [TagW-1:0]      block_number_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           sts_o,
  output logic                 hit_o,
  output logic [WayFieldW-1:0] way_o,
  output logic                 fill_o
);

  localparam int unsigned IdxW = $clog2(NWAYS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NWAYS - 1);

  logic [TagW-1:0]     tags_q [NWAYS];
  logic [AGE_BITS-1:0] ages_q [NWAYS];
  logic [IdxW-1:0]     ptr_q;
  logic                is_write_q;
  logic [TagW-1:0]     tag_q;
  logic [IdxW-1:0]     idx_q;
  logic [IdxW-1:0]     cnt_q;
  logic [IdxW-1:0]     victim_q;
  logic [AGE_BITS-1:0] victim_age_q;
  logic                hit_q;
  logic [WayFieldW-1:0] way_q;
  logic                fill_q;

  logic [IdxW-1:0]     ptr_next;
  logic [IdxW-1:0]     idx_next;
  logic [AGE_BITS-1:0] cur_age;
  logic [AGE_BITS-1:0] aged;
  logic                match;
  logic [31:0]         idx_wide;
  logic [31:0]         victim_wide;

  assign ptr_next    = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
  assign idx_next    = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign cur_age     = ages_q[idx_q];
  assign aged        = (cur_age == '1) ? cur_age : cur_age + 1'b1;
  assign match       = (tags_q[idx_q] == tag_q);
  assign idx_wide    = 32'(idx_q);
  assign victim_wide = 32'(victim_q);

  assign sts_o.match    = match;
  assign sts_o.last     = (cnt_q == LastIdx);
  assign sts_o.is_write = is_write_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NWAYS; i++) begin
        tags_q[i] <= '0;
        ages_q[i] <= '0;
      end
      ptr_q <= '0;
    end else begin
      if (cmd_i.step) begin
        if (match) begin
          ages_q[idx_q] <= '0;
        end else begin
          ages_q[idx_q] <= aged;
        end
        if (!is_write_q) begin
          ptr_q <= idx_q;
        end
      end
      if (cmd_i.alloc) begin
        tags_q[victim_q] <= tag_q;
        ages_q[victim_q] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      is_write_q   <= req_type_i;
      tag_q        <= block_number_i;
      idx_q        <= req_type_i ? '0 : ptr_next;
      cnt_q        <= '0;
      victim_q     <= '0;
      victim_age_q <= ages_q[0];
    end else if (cmd_i.step && !match) begin
      idx_q <= idx_next;
      cnt_q <= cnt_q + 1'b1;
      if (victim_q == idx_q) begin
        victim_age_q <= aged;
      end else if (victim_age_q < aged) begin
        victim_q     <= idx_q;
        victim_age_q <= aged;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.alloc) begin
        hit_q  <= 1'b0;
        way_q  <= victim_wide[WayFieldW-1:0];
        fill_q <= 1'b1;
      end else begin
        hit_q  <= match;
        way_q  <= match ? idx_wide[WayFieldW-1:0] : '0;
        fill_q <= 1'b0;
      end
    end
  end

  assign hit_o  = hit_q;
  assign way_o  = way_q;
  assign fill_o = fill_q;

endmodule

>>> hw/rtl/block_cache_age_replace.sv
// Top level of the block cache tag lookup and age-based replacement logic.
// The request is taken in the idle state, then the scan examines the ways in turn; a read hit ends
// at the matching way, a write at its matching way or after the last way, a read miss in allocation.
// One request at a time; the next transfer is taken the cycle after the result is loaded.
// The result register lets a new request start while the previous result waits to be taken.
// Reset clears all tags, ages and the scan pointer at once; no clearing pass is needed.
`timescale 1ns / 1ps

module block_cache_age_replace
  import bcar_pkg::*;
#(
  parameter int unsigned NWAYS    = 3,
  parameter int unsigned AGE_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bcar_req_if.sink   req_i,
  bcar_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  bcar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcar_dp #(
    .NWAYS    (NWAYS),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_i.req_type),
    .block_number_i (req_i.block_number),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .hit_o          (rsp_o.hit),
    .way_o          (rsp_o.way),
    .fill_o         (rsp_o.fill)
  );

  a_alloc_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc |-> cmd.emit)
    else $error("allocation without result load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending result overwritten");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while a scan is running");

  a_fill_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> !(rsp_o.hit && rsp_o.fill))
    else $error("fill signalled on a hit");

endmodule

>>> tb/bcar_tb_pkg.sv
// Request kind codes shared by the block cache testbench files.
`timescale 1ns / 1ps

package bcar_tb_pkg;

  typedef enum logic {
    ReqRead  = 1'b0,
    ReqWrite = 1'b1
  } req_kind_e;

endpackage

>>> tb/block_cache_age_replace_checker.sv
// Checker that predicts block cache lookups and compares them with the result transfers.
`timescale 1ns / 1ps

module block_cache_age_replace_checker
  import bcar_pkg::*;
  import bcar_tb_pkg::*;
#(
  parameter int unsigned NWAYS    = 3,
  parameter int unsigned AGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcar_req_if         req_i,
  bcar_rsp_if         rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic                 hit;
    logic [WayFieldW-1:0] way;
    logic                 fill;
  } lookup_result_t;

  logic [TagW-1:0]     tag_q [NWAYS];
  logic [AGE_BITS-1:0] age_q [NWAYS];
  int unsigned         scan_q;
  lookup_result_t      predicted_lookup_q [$];
  lookup_result_t      oldest_lookup;
  int unsigned         mismatches;

  function automatic logic [AGE_BITS-1:0] aged(input logic [AGE_BITS-1:0] age);
    return (age == {AGE_BITS{1'b1}}) ? age : age + 1'b1;
  endfunction

  function automatic lookup_result_t lookup_and_replace(input logic is_write,
                                                        input logic [TagW-1:0] blk);
    lookup_result_t res;
    int unsigned    i;
    int unsigned    p;
    int unsigned    victim;
    bit             found;
    res    = '0;
    victim = 0;
    found  = 1'b0;
    if (is_write == ReqWrite) begin
      for (i = 0; i < NWAYS; i++) begin
        if (!found) begin
          if (tag_q[i] == blk) begin
            age_q[i] = '0;
            found    = 1'b1;
            res.way  = WayFieldW'(i);
          end else begin
            age_q[i] = aged(age_q[i]);
          end
        end
      end
    end else begin
      for (i = 0; i < NWAYS; i++) begin
        if (!found) begin
          p      = (scan_q + 1 >= NWAYS) ? 0 : scan_q + 1;
          scan_q = p;
          if (tag_q[p] == blk) begin
            age_q[p] = '0;
            found    = 1'b1;
            res.way  = WayFieldW'(p);
          end else begin
            age_q[p] = aged(age_q[p]);
            if (age_q[victim] < age_q[p]) begin
              victim = p;
            end
          end
        end
      end
      if (!found) begin
        tag_q[victim] = blk;
        age_q[victim] = '0;
        res.way       = WayFieldW'(victim);
        res.fill      = 1'b1;
      end
    end
    res.hit = found;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned w = 0; w < NWAYS; w++) begin
        tag_q[w] = '0;
        age_q[w] = '0;
      end
      scan_q = 0;
      predicted_lookup_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (predicted_lookup_q.size() == 0) begin
          $error("result transfer with no request outstanding: hit=%0d way=%0d fill=%0d",
                 rsp_i.hit, rsp_i.way, rsp_i.fill);
          mismatches++;
        end else begin
          oldest_lookup = predicted_lookup_q.pop_front();
          if (rsp_i.hit !== oldest_lookup.hit) begin
            $error("hit: expected %0d, actual %0d", oldest_lookup.hit, rsp_i.hit);
            mismatches++;
          end
          if (rsp_i.way !== oldest_lookup.way) begin
            $error("way: expected %0d, actual %0d", oldest_lookup.way, rsp_i.way);
            mismatches++;
          end
          if (rsp_i.fill !== oldest_lookup.fill) begin
            $error("fill: expected %0d, actual %0d", oldest_lookup.fill, rsp_i.fill);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predicted_lookup_q.push_back(lookup_and_replace(req_i.req_type, req_i.block_number));
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= predicted_lookup_q.size();
    end
  end

endmodule

>>> tb/block_cache_age_replace_test.sv
// Top of the block cache testbench: clock, reset, request and result traffic, and verdict.
`timescale 1ns / 1ps

module block_cache_age_replace_test;
  import bcar_pkg::*;
  import bcar_tb_pkg::*;

  localparam int unsigned NumWays       = 3;
  localparam int unsigned AgeBits       = 16;
  localparam int unsigned PoolSize      = 6;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 2 * (2 + NumWays) + 10;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stalled_cycles;
  logic [TagW-1:0] block_pool [PoolSize];

  bcar_req_if req_if ();
  bcar_rsp_if rsp_if ();

  block_cache_age_replace #(
    .NWAYS    (NumWays),
    .AGE_BITS (AgeBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  block_cache_age_replace_checker #(
    .NWAYS    (NumWays),
    .AGE_BITS (AgeBits)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    stalled_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= WatchdogLimit) begin
        $display("block_cache_age_replace_test failed");
        $finish;
      end
    end
  end

  task automatic send_req(input req_kind_e kind, input logic [TagW-1:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.block_number <= blk;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic send_random_reqs(input int unsigned count);
    req_kind_e       kind;
    logic [TagW-1:0] blk;
    for (int unsigned n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < 55) ? ReqRead : ReqWrite;
      if ($urandom_range(99) < 70) begin
        blk = block_pool[$urandom_range(PoolSize - 1)];
      end else begin
        blk = $urandom();
      end
      send_req(kind, blk);
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= ReqRead;
    req_if.block_number <= '0;
    send_idle_pct = 28;
    recv_idle_pct = 55;
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int unsigned k = 2; k < PoolSize; k++) begin
      block_pool[k] = $urandom();
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(ReqRead,  32'h0000_0000);
    send_req(ReqWrite, 32'h0000_0000);
    send_req(ReqRead,  32'hFFFF_FFFF);
    send_req(ReqWrite, 32'hFFFF_FFFF);
    send_req(ReqRead,  32'hFFFF_FFFF);
    send_req(ReqWrite, 32'h1234_5678);
    send_req(ReqRead,  32'h0000_0001);
    send_req(ReqRead,  32'h8000_0000);
    send_req(ReqRead,  32'h7FFF_FFFF);
    send_req(ReqRead,  32'h0000_0001);
    send_req(ReqWrite, 32'h8000_0000);
    send_req(ReqWrite, 32'h7FFF_FFFF);
    send_req(ReqRead,  32'h0000_0000);
    send_req(ReqRead,  32'hAAAA_AAAA);
    send_req(ReqRead,  32'h5555_5555);
    send_req(ReqWrite, 32'hAAAA_AAAA);
    send_req(ReqWrite, 32'hDEAD_BEEF);
    send_req(ReqRead,  32'hAAAA_AAAA);
    send_req(ReqRead,  32'h0000_0000);
    send_req(ReqWrite, 32'h5555_5555);
    drain_results();

    send_random_reqs(370);
    drain_results();

    send_idle_pct = 55;
    recv_idle_pct = 28;
    send_random_reqs(370);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_reqs(360);
    drain_results();

    for (int unsigned n = 0; n < 4; n++) begin
      send_req(ReqRead, $urandom());
    end
    send_random_reqs(20);
    drain_results();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("block_cache_age_replace_test passed");
    end else begin
      $display("block_cache_age_replace_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bcar_pkg.sv
hw/rtl/bcar_if.sv
hw/rtl/bcar_ctrl.sv
hw/rtl/bcar_dp.sv
hw/rtl/block_cache_age_replace.sv
tb/bcar_tb_pkg.sv
tb/block_cache_age_replace_checker.sv
tb/block_cache_age_replace_test.sv
